/* rtl/core/life_automaton_torus_step_top_macros.svh */
// Assertion macros for the life automaton block.
// Included by the modules that carry concurrent checks; needs clock and reset in scope.
`ifndef LIFE_AUTOMATON_TORUS_STEP_TOP_MACROS_SVH
`define LIFE_AUTOMATON_TORUS_STEP_TOP_MACROS_SVH

// same-cycle implication
`define LIFETS_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LIFETS_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/lifets_pkg.sv */
// Shared types, constants and the generation rule for the life automaton block.
// No dependencies.
package lifets_pkg;

   localparam int GRID_WIDTH  = 32;
   localparam int GRID_HEIGHT = 32;

   localparam int COL_W = $clog2(GRID_WIDTH);
   localparam int ROW_W = $clog2(GRID_HEIGHT);
   localparam int CNT_W = $clog2(GRID_HEIGHT + 3);

   localparam int BIRTH_COUNT   = 3;
   localparam int SURVIVE_COUNT = 2;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [1:0] CMD_TOGGLE  = 2'd0;
   localparam logic [1:0] CMD_ADVANCE = 2'd1;

   typedef enum logic [1:0] {
      OP_TOGGLE,
      OP_ADVANCE,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type           op;
      logic             in_grid;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } cmd_type;

   function automatic logic [GRID_WIDTH-1:0] lifets_next_row(
      input logic [GRID_WIDTH-1:0] above,
      input logic [GRID_WIDTH-1:0] mid,
      input logic [GRID_WIDTH-1:0] below
   );
      logic [GRID_WIDTH-1:0] result;
      logic [3:0]            n;
      int                    cl;
      int                    cr;
      result = '0;
      for (int c = 0; c < GRID_WIDTH; c++) begin
         cl = (c == 0) ? GRID_WIDTH - 1 : c - 1;
         cr = (c == GRID_WIDTH - 1) ? 0 : c + 1;
         n = {3'b0, above[cl]} + {3'b0, above[c]} + {3'b0, above[cr]}
           + {3'b0, mid[cl]}   + {3'b0, mid[cr]}
           + {3'b0, below[cl]} + {3'b0, below[c]} + {3'b0, below[cr]};
         result[c] = (n == 4'(BIRTH_COUNT))
                   || (mid[c] && (n == 4'(SURVIVE_COUNT)));
      end
      return result;
   endfunction

endpackage

/* rtl/core/lifets_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lifets_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/lifets_front.sv */
// Front end: takes request beats, decodes the command and range-checks the address,
// and holds decoded commands in a short queue for the back end. Uses lifets_pkg.
module lifets_front import lifets_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [4:0] req_col,
   input  logic [4:0] req_row,
   output logic       q_valid,
   output cmd_type    q_cmd,
   input  logic       q_pop
);

   cmd_type              q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   cmd_type              dec;
   logic                 push;
   logic                 pop;

   always_comb begin
      unique case (req_command)
         CMD_TOGGLE:  dec.op = OP_TOGGLE;
         CMD_ADVANCE: dec.op = OP_ADVANCE;
         default:     dec.op = OP_READ;
      endcase
      dec.in_grid = (int'(req_col) < GRID_WIDTH) && (int'(req_row) < GRID_HEIGHT);
      dec.col     = COL_W'(req_col);
      dec.row     = ROW_W'(req_row);
   end

   assign req_stall = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_cmd     = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

/* rtl/core/lifets_back.sv */
// Back end: executes toggle, read and generation commands against the grid RAM,
// sweeping rows through a three-row window, and drives the response beat.
// Uses lifets_pkg, lifets_ram and the assertion macros.
`include "life_automaton_torus_step_top_macros.svh"

module lifets_back import lifets_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_cmd,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output logic    rsp_alive
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADV,
      S_ISSUE,
      S_WAIT,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   cmd_type                cmd_ff, cmd_in;
   logic [GRID_WIDTH-1:0]  above_ff, above_in;
   logic [GRID_WIDTH-1:0]  mid_ff, mid_in;
   logic [GRID_WIDTH-1:0]  first_ff, first_in;
   logic [GRID_HEIGHT-1:0] row_vld_ff, row_vld_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_alive_ff, rsp_alive_in;

   logic                   ram_we;
   logic [ROW_W-1:0]       ram_waddr;
   logic [GRID_WIDTH-1:0]  ram_wdata;
   logic                   ram_re;
   logic [ROW_W-1:0]       ram_raddr;
   logic [GRID_WIDTH-1:0]  ram_rdata;

   logic [GRID_WIDTH-1:0]  rd_row;
   logic [GRID_WIDTH-1:0]  below;
   logic [GRID_WIDTH-1:0]  new_row;
   logic [GRID_WIDTH-1:0]  tog_row;
   logic [GRID_WIDTH-1:0]  final_row;
   logic                   last_step;
   logic                   out_free;

   lifets_ram #(
      .WIDTH (GRID_WIDTH),
      .DEPTH (GRID_HEIGHT)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // rows never written since reset read as dead
   assign rd_row    = rd_vld_ff ? ram_rdata : '0;
   assign last_step = (cnt_ff == CNT_W'(GRID_HEIGHT + 2));
   assign below     = last_step ? first_ff : rd_row;
   assign new_row   = lifets_next_row(above_ff, mid_ff, below);
   assign tog_row   = rd_row ^ (GRID_WIDTH'(1) << cmd_ff.col);
   assign final_row = ram_we ? tog_row : rd_row;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      ram_re    = 1'b0;
      ram_raddr = '0;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      unique case (state_ff)
         S_IDLE: begin
            ram_re    = q_valid && (q_cmd.op != OP_ADVANCE);
            ram_raddr = q_cmd.row;
         end
         S_ADV: begin
            ram_re    = (cnt_ff <= CNT_W'(GRID_HEIGHT));
            ram_raddr = (cnt_ff == '0) ? ROW_W'(GRID_HEIGHT - 1) : ROW_W'(cnt_ff - 1'b1);
            ram_we    = (cnt_ff >= CNT_W'(3));
            ram_waddr = ROW_W'(cnt_ff - CNT_W'(3));
            ram_wdata = new_row;
         end
         S_ISSUE: begin
            ram_re    = 1'b1;
            ram_raddr = cmd_ff.row;
         end
         S_WAIT: begin
            ram_we    = (cmd_ff.op == OP_TOGGLE) && cmd_ff.in_grid;
            ram_waddr = cmd_ff.row;
            ram_wdata = tog_row;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      above_in     = above_ff;
      mid_in       = mid_ff;
      first_in     = first_ff;
      row_vld_in   = row_vld_ff;
      rd_vld_in    = rd_vld_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_alive_in = rsp_alive_ff;

      if (ram_re) begin
         rd_vld_in = row_vld_ff[ram_raddr];
      end
      if (ram_we) begin
         row_vld_in[ram_waddr] = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               cmd_in   = q_cmd;
               cnt_in   = '0;
               state_in = (q_cmd.op == OP_ADVANCE) ? S_ADV : S_WAIT;
            end
         end
         S_ADV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               above_in = rd_row;
            end else if (cnt_ff == CNT_W'(2)) begin
               mid_in   = rd_row;
               first_in = rd_row;
            end else if (cnt_ff >= CNT_W'(3)) begin
               above_in = mid_ff;
               mid_in   = rd_row;
            end
            if (last_step) begin
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            res_in   = cmd_ff.in_grid && final_row[cmd_ff.col];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_alive_in = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         row_vld_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_vld_ff   <= row_vld_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      above_ff     <= above_in;
      mid_ff       <= mid_in;
      first_ff     <= first_in;
      res_ff       <= res_in;
      rsp_alive_ff <= rsp_alive_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_alive = rsp_alive_ff;

   `LIFETS_CHECK(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr, "row clash")
   `LIFETS_CHECK(a_rows_valid_after_step, state_ff == S_ISSUE, &row_vld_ff, "unwritten row")
   `LIFETS_CHECK(a_out_dead, state_ff == S_WAIT && !cmd_ff.in_grid, !res_in, "live outside")

endmodule

/* rtl/core/life_automaton_torus_step_top.sv */
// Top level of the toroidal B3/S23 life automaton: front end, command queue and back end.
// Uses lifets_pkg, lifets_front and lifets_back.
//
//   beat      ports                                     direction
//   request   req_valid req_stall req_command/col/row   in
//   response  rsp_valid rsp_stall rsp_alive             out
//
// Toggle and read go from queue head to response beat through RAM read, write-back
// and output register.
// A generation sweeps the grid one row per cycle through the RAM read port.
// Reset is synchronous; per-row valid bits make the grid read as all dead at once.
// The two-entry queue takes request beats while the back end works or the response stalls.
module life_automaton_torus_step_top import lifets_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [4:0] req_col,
   input  logic [4:0] req_row,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_alive
);

   logic    q_valid;
   cmd_type q_cmd;
   logic    q_pop;

   lifets_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_col     (req_col),
      .req_row     (req_row),
      .q_valid     (q_valid),
      .q_cmd       (q_cmd),
      .q_pop       (q_pop)
   );

   lifets_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_alive (rsp_alive)
   );

endmodule

/* test/life_automaton_torus_step_top_check.sv */
// Checker for the life automaton top: watches both beat channels, keeps its own grid and
// predicts each response. Depends on lifets_pkg for the grid size and command codes.
module life_automaton_torus_step_top_check import lifets_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [4:0] req_col,
   input  logic [4:0] req_row,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_alive,
   output int         fail_count,
   output int         pending,
   output int         toggles,
   output int         generations,
   output int         reads,
   output int         live_seen
);

   logic [GRID_WIDTH-1:0] cells [GRID_HEIGHT];
   logic                  alive_queue [$];
   logic                  wanted_alive;

   task automatic step_generation();
      logic [GRID_WIDTH-1:0] old_cells [GRID_HEIGHT];
      int                    neighbours;
      int                    nr;
      int                    nc;
      old_cells = cells;
      for (int r = 0; r < GRID_HEIGHT; r++) begin
         for (int c = 0; c < GRID_WIDTH; c++) begin
            neighbours = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if (dr != 0 || dc != 0) begin
                     nr = (r + dr + GRID_HEIGHT) % GRID_HEIGHT;
                     nc = (c + dc + GRID_WIDTH) % GRID_WIDTH;
                     neighbours += int'(old_cells[nr][nc]);
                  end
               end
            end
            cells[r][c] = (neighbours == 3) || (old_cells[r][c] && neighbours == 2);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (cells[r]) cells[r] = '0;
         alive_queue.delete();
         fail_count  = 0;
         toggles     = 0;
         generations = 0;
         reads       = 0;
         live_seen   = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (alive_queue.size() == 0) begin
               fail_count++;
               $error("alive: response beat with nothing expected, actual %0b", rsp_alive);
            end else begin
               wanted_alive = alive_queue.pop_front();
               if (rsp_alive !== wanted_alive) begin
                  fail_count++;
                  $error("alive mismatch: expected %0b, actual %0b", wanted_alive, rsp_alive);
               end
            end
            if (rsp_alive === 1'b1) live_seen++;
         end
         if (req_valid && !req_stall) begin
            if (req_command == CMD_TOGGLE) begin
               cells[req_row][req_col] = ~cells[req_row][req_col];
               toggles++;
            end else if (req_command == CMD_ADVANCE) begin
               step_generation();
               generations++;
            end else begin
               reads++;
            end
            alive_queue.push_back(cells[req_row][req_col]);
         end
      end
      pending = alive_queue.size();
   end

endmodule

/* test/life_automaton_torus_step_top_test.sv */
// Testbench top for the life automaton: clock, reset, request stimulus, response stall and verdict.
// Depends on lifets_pkg, life_automaton_torus_step_top and life_automaton_torus_step_top_check.
module life_automaton_torus_step_top_test;
   import lifets_pkg::*;

   localparam logic [1:0] CMD_READ     = 2'(OP_READ);
   localparam logic [1:0] CMD_SPARE    = 2'd3;
   localparam int         PHASE_BEATS  = 200;
   localparam int         QUIET_LIMIT  = 2000;
   localparam int         DRAIN_CYCLES = 3 * (GRID_HEIGHT + 7);

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [1:0] req_command = CMD_READ;
   logic [4:0] req_col     = '0;
   logic [4:0] req_row     = '0;
   logic       rsp_stall   = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_alive;

   int         fail_count;
   int         pending;
   int         toggles;
   int         generations;
   int         reads;
   int         live_seen;
   int         beats_sent    = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         quiet_cycles;
   int         phase_end;
   logic [4:0] anchor_col = '0;
   logic [4:0] anchor_row = '0;

   life_automaton_torus_step_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_col(req_col), .req_row(req_row),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_alive(rsp_alive)
   );

   life_automaton_torus_step_top_check checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_col(req_col), .req_row(req_row),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_alive(rsp_alive),
      .fail_count(fail_count), .pending(pending), .toggles(toggles),
      .generations(generations), .reads(reads), .live_seen(live_seen)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   task automatic send_beat(input logic [1:0] cmd, input logic [4:0] c, input logic [4:0] r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_col     <= c;
      req_row     <= r;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   task automatic probe_anchor(input int count);
      repeat (count) begin
         send_beat(($urandom_range(0, 3) == 0) ? CMD_SPARE : CMD_READ,
                   anchor_col + 5'($urandom_range(0, 8)) - 5'd2,
                   anchor_row + 5'($urandom_range(0, 8)) - 5'd2);
      end
   endtask

   task automatic random_sequence();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         anchor_col = 5'($urandom);
         anchor_row = 5'($urandom);
         repeat ($urandom_range(3, 10)) begin
            send_beat(CMD_TOGGLE, anchor_col + 5'($urandom_range(0, 4)),
                      anchor_row + 5'($urandom_range(0, 4)));
         end
         repeat ($urandom_range(1, 4)) begin
            send_beat(CMD_ADVANCE, 5'($urandom), 5'($urandom));
            probe_anchor($urandom_range(1, 4));
         end
      end else if (kind == 6) begin
         anchor_col = 5'($urandom);
         anchor_row = 5'($urandom);
         send_beat(CMD_TOGGLE, anchor_col + 5'd1, anchor_row);
         send_beat(CMD_TOGGLE, anchor_col + 5'd2, anchor_row + 5'd1);
         send_beat(CMD_TOGGLE, anchor_col,        anchor_row + 5'd2);
         send_beat(CMD_TOGGLE, anchor_col + 5'd1, anchor_row + 5'd2);
         send_beat(CMD_TOGGLE, anchor_col + 5'd2, anchor_row + 5'd2);
         repeat ($urandom_range(4, 8)) begin
            send_beat(CMD_ADVANCE, anchor_col + 5'd1, anchor_row + 5'd1);
            probe_anchor($urandom_range(0, 2));
         end
      end else if (kind == 7) begin
         probe_anchor($urandom_range(2, 6));
      end else begin
         repeat ($urandom_range(3, 6)) begin
            send_beat(2'($urandom_range(0, 3)), 5'($urandom), 5'($urandom));
         end
      end
   endtask

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // blinker across the column seam, then across the row seam
      send_beat(CMD_READ,    5'd0,  5'd0);
      send_beat(CMD_SPARE,   5'd31, 5'd31);
      send_beat(CMD_TOGGLE,  5'd31, 5'd0);
      send_beat(CMD_TOGGLE,  5'd0,  5'd0);
      send_beat(CMD_TOGGLE,  5'd1,  5'd0);
      send_beat(CMD_READ,    5'd0,  5'd0);
      send_beat(CMD_ADVANCE, 5'd0,  5'd31);
      send_beat(CMD_READ,    5'd0,  5'd31);
      send_beat(CMD_SPARE,   5'd31, 5'd0);
      send_beat(CMD_ADVANCE, 5'd31, 5'd0);
      send_beat(CMD_READ,    5'd1,  5'd0);
      send_beat(CMD_TOGGLE,  5'd1,  5'd0);
      send_beat(CMD_TOGGLE,  5'd1,  5'd0);
      send_beat(CMD_ADVANCE, 5'd0,  5'd0);
      send_beat(CMD_TOGGLE,  5'd31, 5'd31);
      send_beat(CMD_TOGGLE,  5'd0,  5'd31);
      send_beat(CMD_ADVANCE, 5'd31, 5'd31);
      send_beat(CMD_READ,    5'd31, 5'd31);
      send_beat(CMD_TOGGLE,  5'd16, 5'd15);
      send_beat(CMD_ADVANCE, 5'd16, 5'd15);
      send_beat(CMD_READ,    5'd31, 5'd0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 45;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 45;
            end
            default: begin
               send_idle_pct  = 35;
               recv_stall_pct = 35;
            end
         endcase
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end) random_sequence();
         // hold the sender until every response is back
         req_valid <= 1'b0;
         do @(posedge clock); while (pending != 0);
      end

      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request beats: %0d toggles, %0d generations, %0d reads",
               beats_sent, toggles, generations, reads);
      $display("%0d responses saw a live cell, across four sender/receiver pacing phases",
               live_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/lifets_pkg.sv
rtl/core/lifets_ram.sv
rtl/core/lifets_front.sv
rtl/core/lifets_back.sv
rtl/core/life_automaton_torus_step_top.sv
test/life_automaton_torus_step_top_check.sv
test/life_automaton_torus_step_top_test.sv
